FILE: rtl/core/descriptor_ring_pointer_control_top_macros.svh
// Assertion macros shared by the descriptor ring pointer control RTL.
`ifndef DESCRIPTOR_RING_POINTER_CONTROL_TOP_MACROS_SVH
`define DESCRIPTOR_RING_POINTER_CONTROL_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset.
`define DRPC_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define DRPC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the next cycle.
`define DRPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DRPC_ASSERT(lbl, cond, msg)
`define DRPC_ASSERT_IMPLY(lbl, ante, cons, msg)
`define DRPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/drpc_pkg.sv
// Types, codes and helper functions of the descriptor ring pointer control.
`timescale 1ns / 1ps

package drpc_pkg;

    localparam int IDX_W    = 16;
    localparam int CREDIT_W = 32;
    localparam int ADDR_W   = 64;
    localparam int SIZE_W   = 5;
    localparam int MAG_W    = 15;
    localparam int COMP_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [COMP_W-1:0]   COMP_FLAG   = 16'h8000;
    localparam logic [2:0]          ALIGN_MASK  = 3'h7;
    localparam logic [CREDIT_W-1:0] CREDIT_MAX  = 32'hFFFF_FFFF;
    localparam logic [SIZE_W-1:0]   SIZE_RESET  = 5'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE = 2'd0,
        REG_SIZE = 2'd1
    } drpc_reg_t;

    typedef enum logic [1:0] {
        KIND_SET_HEAD = 2'd0,
        KIND_FETCH    = 2'd1,
        KIND_POST     = 2'd2,
        KIND_RETURN   = 2'd3
    } drpc_kind_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_BASE_UNSET  = 3'd2,
        ST_HEAD_RANGE  = 3'd3,
        ST_HEAD_WRAP   = 3'd4,
        ST_CREDIT_OVER = 3'd5
    } drpc_status_t;

    typedef struct packed {
        logic [IDX_W-1:0]    head;
        logic [IDX_W-1:0]    tail;
        logic [CREDIT_W-1:0] credits;
    } drpc_state_t;

    typedef struct packed {
        drpc_kind_t          kind;
        logic [IDX_W-1:0]    new_head;
        logic [MAG_W-1:0]    error_magnitude;
        logic [CREDIT_W-1:0] credit_count;
    } drpc_req_t;

    typedef struct packed {
        drpc_status_t        status;
        logic [IDX_W-1:0]    desc_index;
        logic [ADDR_W-1:0]   desc_addr;
        logic [COMP_W-1:0]   completion_word;
        logic                credit_started;
        logic                credits_pending;
        logic [CREDIT_W-1:0] credits_now;
        logic [IDX_W-1:0]    head_now;
        logic [IDX_W-1:0]    tail_now;
    } drpc_result_t;

    // Index mask of a ring of 2**size_log2 entries (size_log2 is 1..16).
    function automatic logic [IDX_W-1:0] ring_mask(input logic [SIZE_W-1:0] size_log2);
        logic [IDX_W:0] full;
        full = ((IDX_W+1)'(1) << size_log2) - (IDX_W+1)'(1);
        return full[IDX_W-1:0];
    endfunction

endpackage

FILE: rtl/core/drpc_step.sv
// One request against the ring state: status, descriptor address and next state.
`timescale 1ns / 1ps

module drpc_step #(
    parameter int DESC_BYTES = 32
) (
    input  drpc_pkg::drpc_req_t               req,
    input  drpc_pkg::drpc_state_t             cur,
    input  logic [drpc_pkg::ADDR_W-1:0]       base,
    input  logic [drpc_pkg::SIZE_W-1:0]       size_log2,
    output drpc_pkg::drpc_state_t             nxt,
    output drpc_pkg::drpc_result_t            res
);

    localparam int DESC_W = $clog2(DESC_BYTES + 1);
    localparam int PROD_W = drpc_pkg::IDX_W + DESC_W;
    localparam logic [DESC_W-1:0] DESC_BYTES_C = DESC_W'(DESC_BYTES);

    logic [drpc_pkg::IDX_W-1:0]    mask;
    logic                          empty;
    logic                          base_unset;
    logic                          head_range_bad;
    logic                          head_wraps;
    logic [PROD_W-1:0]             offset;
    logic [drpc_pkg::ADDR_W-1:0]   addr;
    logic [drpc_pkg::CREDIT_W-1:0] credits_left;

    assign mask           = drpc_pkg::ring_mask(size_log2);
    assign empty          = (cur.head == cur.tail);
    assign base_unset     = (base == '0);
    assign head_range_bad = ((req.new_head & ~mask) != '0);
    // The head may not jump over the tail.
    assign head_wraps     = ((cur.head < cur.tail) &&
                             ((req.new_head >= cur.tail) || (req.new_head < cur.head))) ||
                            ((cur.head > cur.tail) &&
                             ((req.new_head >= cur.tail) && (req.new_head < cur.head)));
    assign offset         = PROD_W'(cur.tail) * PROD_W'(DESC_BYTES_C);
    assign addr           = base + drpc_pkg::ADDR_W'(offset);
    assign credits_left   = cur.credits - req.credit_count;

    always_comb
    begin
        nxt = cur;
        res = '0;
        res.status = drpc_pkg::ST_OK;
        unique case (req.kind) inside
            drpc_pkg::KIND_SET_HEAD:
            begin
                if (base_unset)
                    res.status = drpc_pkg::ST_BASE_UNSET;
                else if (head_range_bad)
                    res.status = drpc_pkg::ST_HEAD_RANGE;
                else if (head_wraps)
                    res.status = drpc_pkg::ST_HEAD_WRAP;
                else
                    nxt.head = req.new_head;
            end
            drpc_pkg::KIND_FETCH, drpc_pkg::KIND_POST:
            begin
                if (empty)
                    res.status = drpc_pkg::ST_EMPTY;
                else if (base_unset)
                    res.status = drpc_pkg::ST_BASE_UNSET;
                else
                begin
                    res.desc_index = cur.tail;
                    res.desc_addr  = addr;
                    if (req.kind == drpc_pkg::KIND_POST)
                    begin
                        res.completion_word = drpc_pkg::COMP_FLAG |
                                              drpc_pkg::COMP_W'(req.error_magnitude);
                        nxt.tail = (cur.tail + drpc_pkg::IDX_W'(1)) & mask;
                        res.credit_started = (cur.credits == '0);
                        // Saturate the credit count.
                        if (cur.credits != drpc_pkg::CREDIT_MAX)
                            nxt.credits = cur.credits + drpc_pkg::CREDIT_W'(1);
                    end
                end
            end
            drpc_pkg::KIND_RETURN:
            begin
                if (req.credit_count > cur.credits)
                begin
                    nxt.credits = '0;
                    res.status  = drpc_pkg::ST_CREDIT_OVER;
                end
                else
                begin
                    nxt.credits         = credits_left;
                    res.credits_pending = (credits_left != '0);
                end
            end
        endcase
        res.credits_now = nxt.credits;
        res.head_now    = nxt.head;
        res.tail_now    = nxt.tail;
    end

endmodule

FILE: rtl/core/descriptor_ring_pointer_control_top.sv
// Top level of the descriptor ring head, tail and credit controller.
`timescale 1ns / 1ps

// Descriptor ring pointer control. Accepts one request per clock while in_stall is
// low and returns one result per request, in order. A request is taken into an
// input register, then evaluated against the head, tail and credit registers in a
// single step and captured in the result register, which drives out_valid; with no
// stall a new request can follow every cycle. While a finished result waits under
// out_stall, one more request is taken into the input register and in_stall then
// holds until the result drains. Configuration writes (index 0 ring base, index 1
// ring size log2) are always ready and must be issued while no request is in
// flight; a misaligned base or out-of-range size write is ignored, and a valid size
// write clears head and tail. No clearing pass is needed after reset.
`include "descriptor_ring_pointer_control_top_macros.svh"

module descriptor_ring_pointer_control_top #(
    parameter int MAX_LOG2_ENTRIES = 16,
    parameter int DESC_BYTES       = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [drpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [drpc_pkg::ADDR_W-1:0]        cfg_data,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         kind,
    input  logic [drpc_pkg::IDX_W-1:0]         new_head,
    input  logic [drpc_pkg::MAG_W-1:0]         error_magnitude,
    input  logic [drpc_pkg::CREDIT_W-1:0]      credit_count,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [2:0]                         status,
    output logic [drpc_pkg::IDX_W-1:0]         desc_index,
    output logic [drpc_pkg::ADDR_W-1:0]        desc_addr,
    output logic [drpc_pkg::COMP_W-1:0]        completion_word,
    output logic                               credit_started,
    output logic                               credits_pending,
    output logic [drpc_pkg::CREDIT_W-1:0]      credits_now,
    output logic [drpc_pkg::IDX_W-1:0]         head_now,
    output logic [drpc_pkg::IDX_W-1:0]         tail_now
);

    localparam logic [drpc_pkg::SIZE_W-1:0] MAX_SIZE_C = drpc_pkg::SIZE_W'(MAX_LOG2_ENTRIES);

    logic [drpc_pkg::ADDR_W-1:0] base_reg, base_next;
    logic [drpc_pkg::SIZE_W-1:0] size_reg, size_next;
    drpc_pkg::drpc_state_t       state_reg, state_next, step_next;
    drpc_pkg::drpc_req_t         req_reg, req_next;
    logic                        req_v_reg, req_v_next;
    drpc_pkg::drpc_result_t      res_reg, res_next, step_res;
    logic                        out_v_reg, out_v_next;

    logic                        in_take;
    logic                        advance;
    logic                        fire;
    logic                        base_wr;
    logic                        size_wr;
    logic [drpc_pkg::SIZE_W-1:0] size_wdata;

    assign cfg_ready  = 1'b1;
    assign size_wdata = cfg_data[drpc_pkg::SIZE_W-1:0];
    assign base_wr    = cfg_valid && cfg_ready && (cfg_index == drpc_pkg::REG_BASE) &&
                        ((cfg_data[2:0] & drpc_pkg::ALIGN_MASK) == 3'd0);
    assign size_wr    = cfg_valid && cfg_ready && (cfg_index == drpc_pkg::REG_SIZE) &&
                        (size_wdata >= drpc_pkg::SIZE_W'(1)) && (size_wdata <= MAX_SIZE_C);

    // Result register moves when empty or drained.
    assign advance  = !out_v_reg || !out_stall;
    assign fire     = req_v_reg && advance;
    assign in_stall = req_v_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    drpc_step #(
        .DESC_BYTES (DESC_BYTES)
    ) u_step (
        .req       (req_reg),
        .cur       (state_reg),
        .base      (base_reg),
        .size_log2 (size_reg),
        .nxt       (step_next),
        .res       (step_res)
    );

    always_comb
    begin
        base_next  = base_wr ? cfg_data : base_reg;
        size_next  = size_wr ? size_wdata : size_reg;
        state_next = fire ? step_next : state_reg;
        if (size_wr)
        begin
            state_next.head = '0;
            state_next.tail = '0;
        end

        req_next.kind            = drpc_pkg::drpc_kind_t'(kind);
        req_next.new_head        = new_head;
        req_next.error_magnitude = error_magnitude;
        req_next.credit_count    = credit_count;
        req_v_next = in_take || (req_v_reg && !advance);

        res_next   = step_res;
        out_v_next = fire || (out_v_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            size_reg  <= drpc_pkg::SIZE_RESET;
            state_reg <= '0;
            req_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            base_reg  <= base_next;
            size_reg  <= size_next;
            state_reg <= state_next;
            req_v_reg <= req_v_next;
            out_v_reg <= out_v_next;
        end
    end

    // Payload: hold unless a new request or result is loaded.
    always_ff @(posedge clk)
    begin
        if (in_take)
            req_reg <= req_next;
        if (fire)
            res_reg <= res_next;
    end

    assign out_valid       = out_v_reg;
    assign status          = res_reg.status;
    assign desc_index      = res_reg.desc_index;
    assign desc_addr       = res_reg.desc_addr;
    assign completion_word = res_reg.completion_word;
    assign credit_started  = res_reg.credit_started;
    assign credits_pending = res_reg.credits_pending;
    assign credits_now     = res_reg.credits_now;
    assign head_now        = res_reg.head_now;
    assign tail_now        = res_reg.tail_now;

    `DRPC_ASSERT(a_ptr_in_ring,
        (((state_reg.head | state_reg.tail) & ~drpc_pkg::ring_mask(size_reg)) == '0),
        "head or tail outside ring")
    `DRPC_ASSERT_NEXT(a_size_clears, size_wr,
        ((state_reg.head == '0) && (state_reg.tail == '0)),
        "size write did not clear pointers")
    `DRPC_ASSERT_IMPLY(a_started_one, (out_v_reg && res_reg.credit_started),
        (res_reg.credits_now == drpc_pkg::CREDIT_W'(1)),
        "first credit not counted as one")
    `DRPC_ASSERT_IMPLY(a_over_clears,
        (out_v_reg && (res_reg.status == drpc_pkg::ST_CREDIT_OVER)),
        ((res_reg.credits_now == '0) && !res_reg.credits_pending),
        "credit over-return not cleared")
    `DRPC_ASSERT_IMPLY(a_comp_ok, (out_v_reg && (res_reg.completion_word != '0)),
        (res_reg.completion_word[15] && (res_reg.status == drpc_pkg::ST_OK)),
        "completion word without successful post")

endmodule

FILE: sim/tb_descriptor_ring_pointer_control_top.sv
// Self-checking testbench of the descriptor ring head, tail and credit controller.
`timescale 1ns / 1ps

module tb_descriptor_ring_pointer_control_top;

    localparam int MAX_LOG2       = 16;
    localparam int DESC_SIZE      = 32;
    localparam int STALL_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MISMATCH_PRINT = 200;

    logic                                clk;
    logic                                rst_n           = 1'b0;
    logic                                cfg_valid       = 1'b0;
    logic                                cfg_ready;
    logic [drpc_pkg::CFG_IDX_W-1:0]      cfg_index       = '0;
    logic [drpc_pkg::ADDR_W-1:0]         cfg_data        = '0;
    logic                                in_valid        = 1'b0;
    logic                                in_stall;
    logic [1:0]                          kind            = '0;
    logic [drpc_pkg::IDX_W-1:0]          new_head        = '0;
    logic [drpc_pkg::MAG_W-1:0]          error_magnitude = '0;
    logic [drpc_pkg::CREDIT_W-1:0]       credit_count    = '0;
    logic                                out_valid;
    logic                                out_stall       = 1'b0;
    logic [2:0]                          status;
    logic [drpc_pkg::IDX_W-1:0]          desc_index;
    logic [drpc_pkg::ADDR_W-1:0]         desc_addr;
    logic [drpc_pkg::COMP_W-1:0]         completion_word;
    logic                                credit_started;
    logic                                credits_pending;
    logic [drpc_pkg::CREDIT_W-1:0]       credits_now;
    logic [drpc_pkg::IDX_W-1:0]          head_now;
    logic [drpc_pkg::IDX_W-1:0]          tail_now;

    // shadow copy of the ring registers
    logic [drpc_pkg::ADDR_W-1:0]         ring_base;
    logic [drpc_pkg::SIZE_W-1:0]         ring_log2;
    logic [drpc_pkg::IDX_W-1:0]          ring_head;
    logic [drpc_pkg::IDX_W-1:0]          ring_tail;
    logic [drpc_pkg::CREDIT_W-1:0]       ring_credits;

    drpc_pkg::drpc_result_t              pending_results[$];
    drpc_pkg::drpc_result_t              oldest;
    int                                  mismatch_cnt = 0;
    int                                  quiet_cycles = 0;
    int                                  send_idle_pct = 0;
    int                                  recv_stall_pct = 0;
    int                                  hold_len = 0;
    int                                  hold_left = 0;

    descriptor_ring_pointer_control_top #(
        .MAX_LOG2_ENTRIES (MAX_LOG2),
        .DESC_BYTES       (DESC_SIZE)
    ) dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [drpc_pkg::IDX_W-1:0] index_mask();
        logic [drpc_pkg::IDX_W:0] full;
        full = ((drpc_pkg::IDX_W+1)'(1) << ring_log2) - (drpc_pkg::IDX_W+1)'(1);
        return full[drpc_pkg::IDX_W-1:0];
    endfunction

    function automatic drpc_pkg::drpc_result_t ring_step(input drpc_pkg::drpc_req_t rq);
        drpc_pkg::drpc_result_t     r;
        logic [drpc_pkg::IDX_W:0]   entries;
        logic [drpc_pkg::IDX_W-1:0] h;
        logic [drpc_pkg::IDX_W-1:0] t;
        logic                       wraps;
        r        = '0;
        r.status = drpc_pkg::ST_OK;
        entries  = (drpc_pkg::IDX_W+1)'(1) << ring_log2;
        h        = ring_head;
        t        = ring_tail;
        case (rq.kind)
            drpc_pkg::KIND_SET_HEAD:
            begin
                if (ring_base == '0)
                    r.status = drpc_pkg::ST_BASE_UNSET;
                else if ({1'b0, rq.new_head} >= entries)
                    r.status = drpc_pkg::ST_HEAD_RANGE;
                else
                begin
                    wraps = (h < t && (rq.new_head >= t || rq.new_head < h)) ||
                            (h > t && (rq.new_head >= t && rq.new_head < h));
                    if (wraps)
                        r.status = drpc_pkg::ST_HEAD_WRAP;
                    else
                        ring_head = rq.new_head;
                end
            end
            drpc_pkg::KIND_FETCH, drpc_pkg::KIND_POST:
            begin
                // empty ring takes precedence over the base check
                if (h == t)
                    r.status = drpc_pkg::ST_EMPTY;
                else if (ring_base == '0)
                    r.status = drpc_pkg::ST_BASE_UNSET;
                else
                begin
                    r.desc_index = t;
                    r.desc_addr  = ring_base +
                                   drpc_pkg::ADDR_W'(t) * drpc_pkg::ADDR_W'(DESC_SIZE);
                    if (rq.kind == drpc_pkg::KIND_POST)
                    begin
                        r.completion_word = drpc_pkg::COMP_FLAG | {1'b0, rq.error_magnitude};
                        ring_tail         = (t + drpc_pkg::IDX_W'(1)) & index_mask();
                        r.credit_started  = (ring_credits == '0);
                        if (ring_credits != drpc_pkg::CREDIT_MAX)
                            ring_credits = ring_credits + drpc_pkg::CREDIT_W'(1);
                    end
                end
            end
            default:
            begin
                if (rq.credit_count > ring_credits)
                begin
                    ring_credits = '0;
                    r.status     = drpc_pkg::ST_CREDIT_OVER;
                end
                else
                begin
                    ring_credits      = ring_credits - rq.credit_count;
                    r.credits_pending = (ring_credits != '0);
                end
            end
        endcase
        r.credits_now = ring_credits;
        r.head_now    = ring_head;
        r.tail_now    = ring_tail;
        return r;
    endfunction

    function automatic void apply_reg_write(input drpc_pkg::drpc_reg_t idx,
                                            input logic [drpc_pkg::ADDR_W-1:0] data);
        if (idx == drpc_pkg::REG_BASE)
        begin
            if ((data[2:0] & drpc_pkg::ALIGN_MASK) == '0)
                ring_base = data;
        end
        else if (idx == drpc_pkg::REG_SIZE)
        begin
            if (data[4:0] >= 5'd1 && data[4:0] <= 5'(MAX_LOG2))
            begin
                ring_log2 = data[4:0];
                ring_head = '0;
                ring_tail = '0;
            end
        end
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_cnt++;
        if (mismatch_cnt <= MISMATCH_PRINT)
            $display("tb: mismatch on %s: got %h, want %h at %0t", what, got, want, $time);
    endtask

    task automatic compare_field(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request outstanding", '0, '0);
            else
            begin
                oldest = pending_results.pop_front();
                compare_field("status", 64'(status), 64'(oldest.status));
                compare_field("desc_index", 64'(desc_index), 64'(oldest.desc_index));
                compare_field("desc_addr", desc_addr, oldest.desc_addr);
                compare_field("completion_word", 64'(completion_word),
                              64'(oldest.completion_word));
                compare_field("credit_started", 64'(credit_started),
                              64'(oldest.credit_started));
                compare_field("credits_pending", 64'(credits_pending),
                              64'(oldest.credits_pending));
                compare_field("credits_now", 64'(credits_now), 64'(oldest.credits_now));
                compare_field("head_now", 64'(head_now), 64'(oldest.head_now));
                compare_field("tail_now", 64'(tail_now), 64'(oldest.tail_now));
            end
        end
    end

    // end the run when no handshake completes for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stall, or a long hold-off when one is requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_len != 0)
            begin
                hold_left = hold_len;
                hold_len  = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------- request side

    function automatic drpc_pkg::drpc_req_t make_req(
        input drpc_pkg::drpc_kind_t          k,
        input logic [drpc_pkg::IDX_W-1:0]    nh,
        input logic [drpc_pkg::MAG_W-1:0]    mag,
        input logic [drpc_pkg::CREDIT_W-1:0] cnt);
        drpc_pkg::drpc_req_t rq;
        rq.kind            = k;
        rq.new_head        = nh;
        rq.error_magnitude = mag;
        rq.credit_count    = cnt;
        return rq;
    endfunction

    // mostly legal traffic against the current shadow state, the rest noise
    function automatic drpc_pkg::drpc_req_t random_req();
        drpc_pkg::drpc_req_t        rq;
        int unsigned                pick;
        int unsigned                sel;
        logic [drpc_pkg::IDX_W-1:0] room;
        rq.new_head        = drpc_pkg::IDX_W'($urandom);
        rq.error_magnitude = drpc_pkg::MAG_W'($urandom);
        rq.credit_count    = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            rq.kind = drpc_pkg::KIND_SET_HEAD;
            if ($urandom_range(0, 99) < 80)
            begin
                // advance the head without passing the tail
                room        = (ring_tail - ring_head - drpc_pkg::IDX_W'(1)) & index_mask();
                rq.new_head = (ring_head + drpc_pkg::IDX_W'($urandom_range(0, room))) &
                              index_mask();
            end
        end
        else if (pick < 45)
            rq.kind = drpc_pkg::KIND_FETCH;
        else if (pick < 75)
            rq.kind = drpc_pkg::KIND_POST;
        else
        begin
            rq.kind = drpc_pkg::KIND_RETURN;
            sel = $urandom_range(0, 99);
            if (sel < 70)
                rq.credit_count = $urandom_range(0, ring_credits);
            else if (sel < 85 && ring_credits < drpc_pkg::CREDIT_MAX - 4)
                rq.credit_count = ring_credits + $urandom_range(1, 4);
        end
        return rq;
    endfunction

    task automatic send_req(input drpc_pkg::drpc_req_t rq);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        kind            <= rq.kind;
        new_head        <= rq.new_head;
        error_magnitude <= rq.error_magnitude;
        credit_count    <= rq.credit_count;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(ring_step(rq));
    endtask

    // stop offering and wait until every outstanding request has answered
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input drpc_pkg::drpc_reg_t idx,
                             input logic [drpc_pkg::ADDR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg_write(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_base_unset();
        send_req(make_req(drpc_pkg::KIND_SET_HEAD, 16'd1, '0, '0));
        send_req(make_req(drpc_pkg::KIND_FETCH, '0, '0, '0));
        send_req(make_req(drpc_pkg::KIND_POST, '0, 15'h7FFF, '0));
        send_req(make_req(drpc_pkg::KIND_RETURN, '0, '0, 32'd0));
        send_req(make_req(drpc_pkg::KIND_RETURN, '0, '0, 32'hFFFF_FFFF));
    endtask

    task automatic test_head_checks();
        drain_results();
        write_reg(drpc_pkg::REG_BASE, 64'h1003);
        write_reg(drpc_pkg::REG_BASE, 64'hFFFF_FFFF_FFFF_FFF8);
        send_req(make_req(drpc_pkg::KIND_SET_HEAD, 16'd2, '0, '0));
        send_req(make_req(drpc_pkg::KIND_SET_HEAD, 16'hFFFF, '0, '0));
        send_req(make_req(drpc_pkg::KIND_SET_HEAD, 16'd1, '0, '0));
        send_req(make_req(drpc_pkg::KIND_FETCH, '0, '0, '0));
        send_req(make_req(drpc_pkg::KIND_POST, '0, 15'h7FFF, '0));
        send_req(make_req(drpc_pkg::KIND_SET_HEAD, 16'd0, '0, '0));
        // address wraps past the top of the 64-bit space
        send_req(make_req(drpc_pkg::KIND_POST, '0, 15'h0000, '0));
        send_req(make_req(drpc_pkg::KIND_FETCH, '0, '0, '0));
    endtask

    task automatic test_size_write();
        drain_results();
        write_reg(drpc_pkg::REG_SIZE, 64'd0);
        write_reg(drpc_pkg::REG_SIZE, 64'd17);
        write_reg(drpc_pkg::REG_SIZE, 64'(MAX_LOG2));
        send_req(make_req(drpc_pkg::KIND_SET_HEAD, 16'hFFFF, '0, '0));
        send_req(make_req(drpc_pkg::KIND_SET_HEAD, 16'd5, '0, '0));
        send_req(make_req(drpc_pkg::KIND_SET_HEAD, 16'hFFFF, '0, '0));
        send_req(make_req(drpc_pkg::KIND_RETURN, '0, '0, 32'd1));
        send_req(make_req(drpc_pkg::KIND_POST, '0, 15'h1234, '0));
        send_req(make_req(drpc_pkg::KIND_SET_HEAD, 16'd0, '0, '0));
        send_req(make_req(drpc_pkg::KIND_SET_HEAD, 16'h8000, '0, '0));
    endtask

    task automatic test_base_clear();
        drain_results();
        write_reg(drpc_pkg::REG_BASE, 64'd0);
        send_req(make_req(drpc_pkg::KIND_FETCH, '0, '0, '0));
        send_req(make_req(drpc_pkg::KIND_POST, '0, 15'h0001, '0));
        send_req(make_req(drpc_pkg::KIND_SET_HEAD, 16'd3, '0, '0));
        send_req(make_req(drpc_pkg::KIND_RETURN, '0, '0, 32'd3));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        logic [drpc_pkg::SIZE_W-1:0] size_list[10];
        logic [drpc_pkg::ADDR_W-1:0] base;
        int                          sub;
        size_list = '{5'd1, 5'd2, 5'd3, 5'd4, 5'd2, 5'd16, 5'd5, 5'd3, 5'd1, 5'd8};
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 100 == 0)
            begin
                // pause until every answer is in, then reconfigure
                drain_results();
                sub  = $urandom_range(0, 9);
                base = {$urandom, $urandom} & ~64'h7;
                if (sub == 0)
                    base = 64'hFFFF_FFFF_FFFF_FFF8;
                else if (sub == 1)
                    base = 64'h8;
                else if (sub == 2)
                    base = '0;
                if ($urandom_range(0, 3) == 0)
                    write_reg(drpc_pkg::REG_BASE, {$urandom, $urandom} | 64'h1);
                write_reg(drpc_pkg::REG_BASE, base);
                if ($urandom_range(0, 3) == 0)
                    write_reg(drpc_pkg::REG_SIZE, 64'($urandom_range(17, 31)));
                write_reg(drpc_pkg::REG_SIZE, 64'(size_list[$urandom_range(0, 9)]));
            end
            send_req(random_req());
        end
        drain_results();
    endtask

    task automatic test_backpressure_fill();
        drain_results();
        write_reg(drpc_pkg::REG_BASE, 64'h0000_0000_0010_0000);
        write_reg(drpc_pkg::REG_SIZE, 64'd3);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 400;
        for (int i = 0; i < 120; i++)
            send_req(random_req());
        drain_results();
    endtask

    initial
    begin
        ring_base    = '0;
        ring_log2    = drpc_pkg::SIZE_RESET;
        ring_head    = '0;
        ring_tail    = '0;
        ring_credits = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_base_unset();
        test_head_checks();
        test_size_write();
        test_base_clear();
        test_random_traffic(0, 0, 400);
        test_random_traffic(59, 0, 400);
        test_random_traffic(0, 59, 400);
        test_random_traffic(8, 8, 400);
        test_backpressure_fill();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
